FILE: hw/rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants for the quaternion vector rotation pipeline:
// item and result structs, frame mode codes, Hamilton product sign tables.
// ----------------------------------------------------------------------------
package qvr_pkg;

	localparam int DATA_W     = 16;
	localparam int QUAT_W     = 16;
	localparam int ROT_SHIFT  = 28;
	localparam int FRM_SHIFT  = 16;
	localparam int FRM_C_W    = 17;

	// 1/sqrt(2) in Q0.16, with a zero sign bit
	localparam logic signed [FRM_C_W-1:0] FRM_C = 17'sd46341;

	localparam logic [1:0] FRAME_MODE_ROT  = 2'd0;
	localparam logic [1:0] FRAME_MODE_POST = 2'd1;
	localparam logic [1:0] FRAME_MODE_BOTH = 2'd2;

	typedef struct packed {
		logic signed [QUAT_W-1:0] quat_w;
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
		logic signed [DATA_W-1:0] vec_x;
		logic signed [DATA_W-1:0] vec_y;
		logic signed [DATA_W-1:0] vec_z;
	} qvr_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_x;
		logic signed [DATA_W-1:0] out_y;
		logic signed [DATA_W-1:0] out_z;
		logic                     saturated;
	} qvr_result_t;

	// load enables of a two-stage multiply then reduce unit
	typedef struct packed {
		logic en_mul;
		logic en_sum;
	} qvr_stg_en_t;

	typedef logic [1:0] qvr_idx_t;

	// hamilton product r = a * b: term i of part k is a[i] * b[QM_BIDX[k][i]]
	localparam qvr_idx_t QM_BIDX [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd2, 2'd3, 2'd0, 2'd1},
		'{2'd3, 2'd2, 2'd1, 2'd0}
	};

	// bit i set: term i is subtracted
	localparam logic [3:0] QM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

FILE: hw/rtl/qvr_frame.sv
// ----------------------------------------------------------------------------
// qvr_frame
// Two-stage fixed FRD-to-plus frame transform:
// y = (round16(C*(a0-a1)), round16(-C*(a0+a1)), -a2), C = 1/sqrt(2) in Q0.16.
// ----------------------------------------------------------------------------
module qvr_frame import qvr_pkg::*; #(
	parameter int IN_W = 16
) (
	input  logic                   clk,
	input  qvr_stg_en_t            en,
	input  logic signed [IN_W-1:0] a [3],
	output logic signed [IN_W:0]   y [3]
);

	localparam int DW = IN_W + 1;
	localparam int PW = DW + FRM_C_W;
	localparam logic signed [PW-1:0] RND = PW'(1) << (FRM_SHIFT - 1);

	logic signed [DW-1:0] diff;
	logic signed [DW-1:0] sum;
	logic signed [PW-1:0] prod_d_s1;
	logic signed [PW-1:0] prod_s_s1;
	logic signed [DW-1:0] a2_s1;
	logic signed [PW-1:0] rnd_d;
	logic signed [PW-1:0] rnd_s;

	assign diff = DW'(a[0]) - DW'(a[1]);
	assign sum  = DW'(a[0]) + DW'(a[1]);

	always_ff @(posedge clk) begin
		if (en.en_mul) begin
			prod_d_s1 <= PW'(diff) * PW'(FRM_C);
			prod_s_s1 <= PW'(sum) * PW'(FRM_C);
			a2_s1     <= DW'(a[2]);
		end
	end

	assign rnd_d = prod_d_s1 + RND;
	assign rnd_s = RND - prod_s_s1;

	always_ff @(posedge clk) begin
		if (en.en_sum) begin
			y[0] <= rnd_d[FRM_SHIFT +: DW];
			y[1] <= rnd_s[FRM_SHIFT +: DW];
			y[2] <= -a2_s1;
		end
	end

endmodule

FILE: hw/rtl/qvr_qmul.sv
// ----------------------------------------------------------------------------
// qvr_qmul
// Two-stage exact Hamilton product: sixteen registered partial products,
// then four registered signed sums.
// ----------------------------------------------------------------------------
module qvr_qmul import qvr_pkg::*; #(
	parameter int A_W = 16,
	parameter int B_W = 17
) (
	input  logic                        clk,
	input  qvr_stg_en_t                 en,
	input  logic signed [A_W-1:0]       a [4],
	input  logic signed [B_W-1:0]       b [4],
	output logic signed [A_W+B_W+1:0]   y [4]
);

	localparam int PROD_W = A_W + B_W;
	localparam int SUM_W  = PROD_W + 2;

	logic signed [PROD_W-1:0] prod_s1 [4][4];
	logic signed [SUM_W-1:0]  acc [4];

	always_ff @(posedge clk) begin
		if (en.en_mul) begin
			for (int k = 0; k < 4; k++) begin
				for (int i = 0; i < 4; i++) begin
					prod_s1[k][i] <= PROD_W'(a[i]) * PROD_W'(b[QM_BIDX[k][i]]);
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			acc[k] = '0;
			for (int i = 0; i < 4; i++) begin
				if (QM_NEG[k][i]) begin
					acc[k] = acc[k] - SUM_W'(prod_s1[k][i]);
				end else begin
					acc[k] = acc[k] + SUM_W'(prod_s1[k][i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_sum) begin
			y <= acc;
		end
	end

endmodule

FILE: hw/rtl/quaternion_vector_rotation.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// Rotates a vector by an unnormalized quaternion, v' = q (0,v) conj(q), with
// an optional fixed frame transform after, or before and after, the rotation.
//
//   channel  direction  handshake                   payload
//   item     in         item_valid / item_stall     qvr_item_t
//   result   out        result_valid / result_stall qvr_result_t
//   config   in         cfg_we                      cfg_wdata (frame mode)
//
// One item per cycle while the result is not stalled, through ten register
// stages: pre-transform (2), two Hamilton products (2 each), rounding (1),
// post-transform (2), saturation into the result register (1).
// Reset clears the stage valid bits and the frame mode.
// A stage holds only while the stage after it is full and held, so bubbles
// close up and items keep entering while a result waits.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation import qvr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  qvr_item_t   item,
	output logic        result_valid,
	input  logic        result_stall,
	output qvr_result_t result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);

	localparam int NSTG  = 10;
	localparam int PRE_W = DATA_W + 1;
	localparam int H1_W  = QUAT_W + PRE_W + 2;
	localparam int QC_W  = QUAT_W + 1;
	localparam int H2_W  = H1_W + QC_W + 2;
	localparam int ROT_W = H2_W - ROT_SHIFT;
	localparam int FIN_W = ROT_W + 1;
	localparam logic signed [H2_W-1:0]  ROT_RND = H2_W'(1) << (ROT_SHIFT - 1);
	localparam logic signed [FIN_W-1:0] SAT_MAX = FIN_W'(2 ** (DATA_W - 1) - 1);
	localparam logic signed [FIN_W-1:0] SAT_MIN = FIN_W'(-(2 ** (DATA_W - 1)));

	logic [1:0]        frame_mode_q;
	logic              pre_en;
	logic              post_en;

	logic [NSTG:1]     stg_valid_q;
	logic [NSTG:1]     valid_in;
	logic [NSTG+1:1]   rdy;

	logic signed [QUAT_W-1:0] q_in [4];
	logic signed [DATA_W-1:0] v_in [3];
	logic signed [QUAT_W-1:0] q_s1 [4];
	logic signed [QUAT_W-1:0] q_s2 [4];
	logic signed [QUAT_W-1:0] q_s3 [4];
	logic signed [QUAT_W-1:0] q_s4 [4];
	logic signed [DATA_W-1:0] v_s1 [3];
	logic signed [DATA_W-1:0] v_s2 [3];

	logic signed [PRE_W-1:0]  pre_y [3];
	logic signed [PRE_W-1:0]  h1_b [4];
	logic signed [H1_W-1:0]   p_s4 [4];
	logic signed [QC_W-1:0]   qc [4];
	logic signed [H2_W-1:0]   r_s6 [4];
	logic signed [H2_W-1:0]   rnd_r [3];
	logic signed [ROT_W-1:0]  rot_s7 [3];
	logic signed [ROT_W-1:0]  rot_s8 [3];
	logic signed [ROT_W-1:0]  rot_s9 [3];
	logic signed [FIN_W-1:0]  post_y [3];
	logic signed [FIN_W-1:0]  fin [3];
	logic signed [DATA_W-1:0] clip [3];
	logic [2:0]               clip_flag;
	qvr_result_t              res_s10;

	// frame mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= FRAME_MODE_ROT;
		end else if (cfg_we) begin
			frame_mode_q <= cfg_wdata;
		end
	end

	assign pre_en  = (frame_mode_q == FRAME_MODE_BOTH);
	assign post_en = (frame_mode_q != FRAME_MODE_ROT);

	// stage flow control
	always_comb begin
		rdy[NSTG+1] = !result_stall;
		for (int k = NSTG; k >= 1; k--) begin
			rdy[k] = !stg_valid_q[k] || rdy[k+1];
		end
	end

	assign valid_in = {stg_valid_q[NSTG-1:1], item_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_valid_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (rdy[k]) begin
					stg_valid_q[k] <= valid_in[k];
				end
			end
		end
	end

	assign item_stall   = !rdy[1];
	assign result_valid = stg_valid_q[NSTG];
	assign result       = res_s10;

	assign q_in = '{item.quat_w, item.quat_x, item.quat_y, item.quat_z};
	assign v_in = '{item.vec_x, item.vec_y, item.vec_z};

	// s1, s2: frame transform ahead of the rotation
	qvr_frame #(
		.IN_W (DATA_W)
	) u_frame_pre (
		.clk (clk),
		.en  ('{en_mul: rdy[1], en_sum: rdy[2]}),
		.a   (v_in),
		.y   (pre_y)
	);

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			q_s1 <= q_in;
			v_s1 <= v_in;
		end
		if (rdy[2]) begin
			q_s2 <= q_s1;
			v_s2 <= v_s1;
		end
		if (rdy[3]) begin
			q_s3 <= q_s2;
		end
		if (rdy[4]) begin
			q_s4 <= q_s3;
		end
	end

	// s3, s4: p = q * (0, v)
	always_comb begin
		h1_b[0] = '0;
		for (int i = 0; i < 3; i++) begin
			h1_b[i+1] = pre_en ? pre_y[i] : PRE_W'(v_s2[i]);
		end
	end

	qvr_qmul #(
		.A_W (QUAT_W),
		.B_W (PRE_W)
	) u_qmul_qv (
		.clk (clk),
		.en  ('{en_mul: rdy[3], en_sum: rdy[4]}),
		.a   (q_s2),
		.b   (h1_b),
		.y   (p_s4)
	);

	// s5, s6: r = p * conj(q)
	always_comb begin
		qc[0] = QC_W'(q_s4[0]);
		for (int i = 1; i < 4; i++) begin
			qc[i] = -QC_W'(q_s4[i]);
		end
	end

	qvr_qmul #(
		.A_W (H1_W),
		.B_W (QC_W)
	) u_qmul_pq (
		.clk (clk),
		.en  ('{en_mul: rdy[5], en_sum: rdy[6]}),
		.a   (p_s4),
		.b   (qc),
		.y   (r_s6)
	);

	// s7: round off the 2^28 scale
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd_r[i] = r_s6[i+1] + ROT_RND;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			for (int i = 0; i < 3; i++) begin
				rot_s7[i] <= rnd_r[i][ROT_SHIFT +: ROT_W];
			end
		end
		if (rdy[8]) begin
			rot_s8 <= rot_s7;
		end
		if (rdy[9]) begin
			rot_s9 <= rot_s8;
		end
	end

	// s8, s9: frame transform after the rotation
	qvr_frame #(
		.IN_W (ROT_W)
	) u_frame_post (
		.clk (clk),
		.en  ('{en_mul: rdy[8], en_sum: rdy[9]}),
		.a   (rot_s7),
		.y   (post_y)
	);

	// s10: select and saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fin[i] = post_en ? post_y[i] : FIN_W'(rot_s9[i]);
			if (fin[i] > SAT_MAX) begin
				clip[i]      = SAT_MAX[DATA_W-1:0];
				clip_flag[i] = 1'b1;
			end else if (fin[i] < SAT_MIN) begin
				clip[i]      = SAT_MIN[DATA_W-1:0];
				clip_flag[i] = 1'b1;
			end else begin
				clip[i]      = fin[i][DATA_W-1:0];
				clip_flag[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[10]) begin
			res_s10.out_x     <= clip[0];
			res_s10.out_y     <= clip[1];
			res_s10.out_z     <= clip[2];
			res_s10.saturated <= |clip_flag;
		end
	end

endmodule

FILE: dv/qvr_rotation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qvr_rotation_checker
// Watches the item, result and config channels of the quaternion vector
// rotation block. Every accepted item is rotated here in exact 64-bit integer
// arithmetic under the current frame mode. Every accepted result is then
// compared field by field, in order, against the oldest rotated vector.
// ----------------------------------------------------------------------------
module qvr_rotation_checker import qvr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  qvr_item_t   item,
	input  logic        result_valid,
	input  logic        result_stall,
	input  qvr_result_t result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	output int          mismatch_count,
	output int          results_owed
);

	logic [1:0]  frame_mode;
	qvr_result_t rotated_q [$];
	qvr_result_t want;

	function automatic longint round_shift(input longint x, input int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic void frd_to_plus(inout longint v [3]);
		longint a0, a1, a2;
		a0 = v[0];
		a1 = v[1];
		a2 = v[2];
		v[0] = round_shift(longint'(FRM_C) * (a0 - a1), FRM_SHIFT);
		v[1] = round_shift(-(longint'(FRM_C) * (a0 + a1)), FRM_SHIFT);
		v[2] = -a2;
	endfunction

	function automatic void hamilton_product(input longint a [4], input longint b [4],
			output longint r [4]);
		r[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
		r[1] = a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2];
		r[2] = a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1];
		r[3] = a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0];
	endfunction

	function automatic logic signed [DATA_W-1:0] clip(input longint x, inout logic flag);
		longint top_val, bot_val;
		top_val = (longint'(1) << (DATA_W - 1)) - 1;
		bot_val = -(longint'(1) << (DATA_W - 1));
		if (x > top_val) begin
			flag = 1'b1;
			return top_val[DATA_W-1:0];
		end
		if (x < bot_val) begin
			flag = 1'b1;
			return bot_val[DATA_W-1:0];
		end
		return x[DATA_W-1:0];
	endfunction

	function automatic qvr_result_t rotate_vector(input qvr_item_t it, input logic [1:0] mode);
		longint q [4], qc [4], vq [4], p [4], r [4], v [3];
		logic sat;
		qvr_result_t res;
		q[0] = longint'(it.quat_w);
		q[1] = longint'(it.quat_x);
		q[2] = longint'(it.quat_y);
		q[3] = longint'(it.quat_z);
		v[0] = longint'(it.vec_x);
		v[1] = longint'(it.vec_y);
		v[2] = longint'(it.vec_z);
		if (mode == FRAME_MODE_BOTH)
			frd_to_plus(v);
		qc[0] = q[0];
		qc[1] = -q[1];
		qc[2] = -q[2];
		qc[3] = -q[3];
		vq[0] = 0;
		vq[1] = v[0];
		vq[2] = v[1];
		vq[3] = v[2];
		hamilton_product(q, vq, p);
		hamilton_product(p, qc, r);
		for (int i = 0; i < 3; i++)
			v[i] = round_shift(r[i + 1], ROT_SHIFT);
		if (mode != FRAME_MODE_ROT)
			frd_to_plus(v);
		sat = 1'b0;
		res.out_x = clip(v[0], sat);
		res.out_y = clip(v[1], sat);
		res.out_z = clip(v[2], sat);
		res.saturated = sat;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode = FRAME_MODE_ROT;
			rotated_q.delete();
			results_owed = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (rotated_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result, expected none, actual x=%0d y=%0d z=%0d sat=%0b",
						$time, result.out_x, result.out_y, result.out_z, result.saturated);
				end else begin
					want = rotated_q.pop_front();
					if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
							result.out_z !== want.out_z || result.saturated !== want.saturated) begin
						mismatch_count++;
						$display("%0t: result mismatch, expected x=%0d y=%0d z=%0d sat=%0b",
							$time, want.out_x, want.out_y, want.out_z, want.saturated);
						$display("%0t:                  actual   x=%0d y=%0d z=%0d sat=%0b",
							$time, result.out_x, result.out_y, result.out_z, result.saturated);
					end
				end
			end
			if (item_valid && !item_stall)
				rotated_q.push_back(rotate_vector(item, frame_mode));
			if (cfg_we)
				frame_mode = cfg_wdata;
			results_owed = rotated_q.size();
		end
	end

endmodule

FILE: dv/tb_quaternion_vector_rotation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotation
// Stimulus and verdict for the quaternion vector rotation block. A directed
// set of extreme and rounding-tie items runs first, then random phases that
// step through every frame mode under different sender and receiver idling,
// including a long result hold-off that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotation import qvr_pkg::*;;

	localparam logic [1:0] FRAME_MODE_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 64;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	qvr_item_t   item_in;
	logic        result_valid;
	logic        result_stall;
	qvr_result_t result_out;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;
	int          mismatch_count;
	int          results_owed;
	int          send_pct;
	int          recv_pct;
	int          holds_asked;
	int          holds_served;

	quaternion_vector_rotation uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_out),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	qvr_rotation_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item_in),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result_out),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

	// receiver stall, with a long hold-off whenever one is asked for
	initial begin
		result_stall = 1'b0;
		holds_served = 0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_served++;
			end else begin
				result_stall <= ($urandom_range(99) < recv_pct);
			end
		end
	end

	function automatic qvr_item_t pack_item(input int w, input int x, input int y, input int z,
			input int a, input int b, input int c);
		qvr_item_t it;
		it.quat_w = w[15:0];
		it.quat_x = x[15:0];
		it.quat_y = y[15:0];
		it.quat_z = z[15:0];
		it.vec_x  = a[15:0];
		it.vec_y  = b[15:0];
		it.vec_z  = c[15:0];
		return it;
	endfunction

	function automatic logic [15:0] corner();
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'hffff;
			2: return 16'h0000;
			3: return 16'h0001;
			default: return 16'h7fff;
		endcase
	endfunction

	function automatic qvr_item_t make_item();
		qvr_item_t it;
		int kind;
		kind = $urandom_range(9);
		it = qvr_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
		if (kind <= 5) begin
			// quaternion parts bounded by +-11585, full-range vector
			it.quat_w = 16'($urandom_range(23170) - 11585);
			it.quat_x = 16'($urandom_range(23170) - 11585);
			it.quat_y = 16'($urandom_range(23170) - 11585);
			it.quat_z = 16'($urandom_range(23170) - 11585);
		end else if (kind == 8) begin
			it = pack_item(corner(), corner(), corner(), corner(), corner(), corner(), corner());
			it.quat_w = corner();
			it.quat_x = corner();
			it.quat_y = corner();
			it.quat_z = corner();
			it.vec_x  = corner();
			it.vec_y  = corner();
			it.vec_z  = corner();
		end else if (kind == 9) begin
			it.quat_w = 16'(16384 + $urandom_range(64) - 32);
			it.quat_x = 16'($urandom_range(64) - 32);
			it.quat_y = 16'($urandom_range(64) - 32);
			it.quat_z = 16'($urandom_range(64) - 32);
			it.vec_x  = 16'($urandom_range(16) - 8);
			it.vec_y  = 16'($urandom_range(16) - 8);
			it.vec_z  = 16'($urandom_range(16) - 8);
		end
		return it;
	endfunction

	task automatic offer(input qvr_item_t it);
		if (send_pct != 0 && $urandom_range(99) < send_pct) begin
			item_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_pct);
		end
		item_valid <= 1'b1;
		item_in <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_mode(input logic [1:0] mode);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [1:0] mode, input int s_pct, input int r_pct,
			input int count);
		write_mode(mode);
		send_pct = s_pct;
		recv_pct <= r_pct;
		repeat (count) offer(make_item());
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item_in = '0;
		cfg_we = 1'b0;
		cfg_wdata = FRAME_MODE_ROT;
		send_pct = 0;
		recv_pct = 0;
		holds_asked = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// rotation only: extremes, axis turns, rounding ties
		offer(pack_item(0, 0, 0, 0, 0, 0, 0));
		offer(pack_item(16384, 0, 0, 0, 32767, -32768, 1));
		offer(pack_item(16384, 0, 0, 0, -32768, -32768, -32768));
		offer(pack_item(-32768, 0, 0, 0, 32767, 32767, 32767));
		offer(pack_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
		offer(pack_item(32767, 32767, 32767, 32767, 32767, 32767, 32767));
		offer(pack_item(0, 16384, 0, 0, 100, 200, 300));
		offer(pack_item(0, 0, 16384, 0, 100, 200, 300));
		offer(pack_item(0, 0, 0, 16384, 100, 200, 300));
		offer(pack_item(11585, 11585, 0, 0, 1000, 2000, 3000));
		offer(pack_item(11585, 0, 11585, 0, 1000, 2000, 3000));
		offer(pack_item(11585, 0, 0, 11585, 1000, 2000, 3000));
		offer(pack_item(8192, 0, 0, 0, 2, -2, 0));
		offer(pack_item(8192, 0, 0, 0, 6, -6, 1));
		offer(pack_item(-1, 1, -1, 1, 32767, -32768, 32767));

		// transform before and after, pre-transform growing past 16 bits
		write_mode(FRAME_MODE_BOTH);
		offer(pack_item(16384, 0, 0, 0, -32768, 32767, -32768));
		offer(pack_item(16384, 0, 0, 0, 32767, -32768, 32767));
		offer(pack_item(-32768, 0, 0, 0, -32768, -32768, -32768));
		offer(pack_item(32767, 32767, 32767, 32767, 32767, -32768, 0));

		write_mode(FRAME_MODE_POST);
		offer(pack_item(16384, 0, 0, 0, 32767, -32768, -32768));
		offer(pack_item(16384, 0, 0, 0, -32768, -32768, 32767));

		// mode value three decodes as post-transform
		write_mode(FRAME_MODE_SPARE);
		offer(pack_item(16384, 0, 0, 0, 32767, 32767, -32768));

		run_phase(FRAME_MODE_POST, 0, 0, 150);
		run_phase(FRAME_MODE_BOTH, 83, 0, 150);
		run_phase(FRAME_MODE_SPARE, 0, 83, 150);
		run_phase(FRAME_MODE_ROT, 14, 14, 200);

		// hold results back while items keep coming, then pause until empty
		run_phase(FRAME_MODE_BOTH, 0, 0, 20);
		holds_asked <= holds_asked + 1;
		repeat (100) offer(make_item());
		drain();
		send_pct = 14;
		recv_pct <= 14;
		repeat (150) offer(make_item());

		run_phase(FRAME_MODE_ROT, 0, 0, 150);
		drain();

		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
